>>> src/tpdu_pkg.sv
// ----------------------------------------------------------------------------
// Tour point distance unit package
// Shared widths, codes and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package tpdu_pkg;

  localparam int unsigned INDEX_W = 10;
  localparam int unsigned COORD_W = 24;
  localparam int unsigned DIST_W  = 21;
  localparam int unsigned MODE_W  = 2;

  localparam int unsigned DIFF_W = COORD_W + 1;
  localparam int unsigned MAG_W  = COORD_W + 1;
  localparam int unsigned SQ_W   = 2 * MAG_W;
  localparam int unsigned SUM_W  = SQ_W;
  localparam int unsigned RAD_W  = SUM_W + 2;
  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam int unsigned REM_W  = ROOT_W + 3;
  localparam int unsigned RND_W  = ROOT_W + 1;

  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned DIV_STEPS  = RAD_W / DIGIT_W;
  localparam int unsigned ROOT_STEPS = ROOT_W;
  localparam int unsigned CNT_W      = $clog2(ROOT_STEPS);

  localparam int unsigned ATT_DIVISOR = 10;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam logic [MODE_W-1:0] MODE_ROUND = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CEIL  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ATT   = 2'd2;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic capture;
    logic quot;
    logic reduce;
    logic write;
    logic diff;
    logic sq_x;
    logic sq_y;
    logic sum;
    logic load;
    logic div_step;
    logic adjust;
    logic root_step;
    logic round;
  } tpdu_cmd_t;

  typedef struct packed {
    logic is_query;
    logic mode_att;
  } tpdu_status_t;

endpackage

>>> src/tpdu_ctrl.sv
// ----------------------------------------------------------------------------
// Tour point distance unit controller
// Sequences index reduction, table access, squaring, the divide by ten and
// the bit-serial square root, and issues one command bundle per cycle.
// ----------------------------------------------------------------------------
module tpdu_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  tpdu_pkg::tpdu_status_t status_i,
  output logic                  busy_o,
  output tpdu_pkg::tpdu_cmd_t   cmd_o
);
  import tpdu_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_QUOT   = 4'd1;
  localparam logic [3:0] ST_REDUCE = 4'd2;
  localparam logic [3:0] ST_WRITE  = 4'd3;
  localparam logic [3:0] ST_READ   = 4'd4;
  localparam logic [3:0] ST_DIFF   = 4'd5;
  localparam logic [3:0] ST_SQX    = 4'd6;
  localparam logic [3:0] ST_SQY    = 4'd7;
  localparam logic [3:0] ST_SUM    = 4'd8;
  localparam logic [3:0] ST_LOAD   = 4'd9;
  localparam logic [3:0] ST_DIV    = 4'd10;
  localparam logic [3:0] ST_ADJ    = 4'd11;
  localparam logic [3:0] ST_ROOT   = 4'd12;
  localparam logic [3:0] ST_ROUND  = 4'd13;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_QUOT;
        end
      end
      ST_QUOT: begin
        cmd_o.quot = 1'b1;
        state_d    = ST_REDUCE;
      end
      ST_REDUCE: begin
        cmd_o.reduce = 1'b1;
        state_d      = status_i.is_query ? ST_READ : ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.write = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_READ: begin
        state_d = ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = ST_SQX;
      end
      ST_SQX: begin
        cmd_o.sq_x = 1'b1;
        state_d    = ST_SQY;
      end
      ST_SQY: begin
        cmd_o.sq_y = 1'b1;
        state_d    = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        if (status_i.mode_att) begin
          cnt_d   = CNT_W'(DIV_STEPS - 1);
          state_d = ST_DIV;
        end else begin
          cnt_d   = CNT_W'(ROOT_STEPS - 1);
          state_d = ST_ROOT;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = ST_ADJ;
        end
      end
      ST_ADJ: begin
        cmd_o.adjust = 1'b1;
        cnt_d        = CNT_W'(ROOT_STEPS - 1);
        state_d      = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        cnt_d           = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

>>> src/tpdu_datapath.sv
// ----------------------------------------------------------------------------
// Tour point distance unit datapath
// Point tables, index reduction, shared squaring multiplier, radix-16
// divide by ten, bit-serial square root and the final rounding.
// ----------------------------------------------------------------------------
module tpdu_datapath #(
  parameter int unsigned POINT_COUNT   = 1024,
  parameter int unsigned FRACTION_BITS = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tpdu_pkg::tpdu_cmd_t               cmd_i,
  output tpdu_pkg::tpdu_status_t            status_o,
  input  logic                              cfg_write_i,
  input  logic [tpdu_pkg::MODE_W-1:0]       cfg_data_i,
  input  logic                              opcode_i,
  input  logic [tpdu_pkg::INDEX_W-1:0]      first_index_i,
  input  logic [tpdu_pkg::INDEX_W-1:0]      second_index_i,
  input  logic signed [tpdu_pkg::COORD_W-1:0] coord_x_i,
  input  logic signed [tpdu_pkg::COORD_W-1:0] coord_y_i,
  output logic                              result_strobe_o,
  output logic [tpdu_pkg::DIST_W-1:0]       distance_o
);
  import tpdu_pkg::*;

  localparam int unsigned ADDR_W      = (POINT_COUNT > 1) ? $clog2(POINT_COUNT) : 1;
  localparam int unsigned RECIP_SHIFT = 2 * INDEX_W;
  localparam int unsigned RECIP_W     = RECIP_SHIFT;
  localparam int unsigned PROD_W      = INDEX_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((2 ** RECIP_SHIFT) + POINT_COUNT - 1) / POINT_COUNT);
  localparam logic [SUM_W-1:0] LOW_MASK =
    (SUM_W'(1) << (2 * FRACTION_BITS)) - SUM_W'(1);
  localparam logic [RND_W-1:0] CEIL_ADD =
    (RND_W'(1) << FRACTION_BITS) - RND_W'(1);

  logic [COORD_W-1:0] x_mem [POINT_COUNT];
  logic [COORD_W-1:0] y_mem [POINT_COUNT];

  logic [MODE_W-1:0]  mode_q;
  logic               strobe_q;
  logic [DIST_W-1:0]  dist_q, dist_d;

  logic               op_q;
  logic [INDEX_W-1:0] idx_a_q, idx_b_q;
  logic [INDEX_W-1:0] quot_a_q, quot_b_q;
  logic [ADDR_W-1:0]  addr_a_q, addr_b_q;
  logic [COORD_W-1:0] cx_q, cy_q;
  logic [COORD_W-1:0] xa_q, xb_q, ya_q, yb_q;
  logic [MAG_W-1:0]   mag_x_q, mag_y_q;
  logic [SQ_W-1:0]    prod_q, acc_q;
  logic [SUM_W-1:0]   sum_q;
  logic               sticky_q;
  logic [RAD_W-1:0]   work_q, work_d;
  logic [DIGIT_W-1:0] div_rem_q, div_rem_d;
  logic [ROOT_W-1:0]  root_q, root_d;
  logic [REM_W-1:0]   rem_q, rem_d;

  logic [PROD_W-1:0]  prod_a, prod_b;
  logic [31:0]        red_a, red_b;
  logic signed [DIFF_W-1:0] dx, dy;
  logic [MAG_W-1:0]   mag_sel;
  logic [SQ_W-1:0]    sq;
  logic [DIGIT_W-1:0] qbits;
  logic [RND_W-1:0]   r_ext, rnd;

  assign status_o.is_query = (op_q == OP_QUERY);
  assign status_o.mode_att = (mode_q == MODE_ATT);
  assign result_strobe_o   = strobe_q;
  assign distance_o        = dist_q;

  assign prod_a = PROD_W'(idx_a_q) * PROD_W'(RECIP);
  assign prod_b = PROD_W'(idx_b_q) * PROD_W'(RECIP);
  assign red_a  = 32'(idx_a_q) - 32'(quot_a_q) * 32'(POINT_COUNT);
  assign red_b  = 32'(idx_b_q) - 32'(quot_b_q) * 32'(POINT_COUNT);

  assign dx = $signed({xa_q[COORD_W-1], xa_q}) - $signed({xb_q[COORD_W-1], xb_q});
  assign dy = $signed({ya_q[COORD_W-1], ya_q}) - $signed({yb_q[COORD_W-1], yb_q});

  assign mag_sel = cmd_i.sq_y ? mag_y_q : mag_x_q;
  assign sq      = SQ_W'(mag_sel) * SQ_W'(mag_sel);

  always_comb begin
    logic [DIGIT_W-1:0] r;
    logic [DIGIT_W:0]   r5;
    r     = div_rem_q;
    qbits = '0;
    for (int j = 0; j < DIGIT_W; j++) begin
      r5 = {r, work_q[RAD_W-1-j]};
      if (r5 >= (DIGIT_W+1)'(ATT_DIVISOR)) begin
        r                  = DIGIT_W'(r5 - (DIGIT_W+1)'(ATT_DIVISOR));
        qbits[DIGIT_W-1-j] = 1'b1;
      end else begin
        r = r5[DIGIT_W-1:0];
      end
    end
    div_rem_d = r;
  end

  always_comb begin
    logic [REM_W-1:0] cand;
    logic [REM_W-1:0] trial;
    cand  = {rem_q[REM_W-3:0], work_q[RAD_W-1 -: 2]};
    trial = {{(REM_W-ROOT_W-2){1'b0}}, root_q, 2'b01};
    if (cand >= trial) begin
      rem_d  = cand - trial;
      root_d = {root_q[ROOT_W-2:0], 1'b1};
    end else begin
      rem_d  = cand;
      root_d = {root_q[ROOT_W-2:0], 1'b0};
    end
  end

  always_comb begin
    unique case (mode_q)
      MODE_CEIL: work_d = RAD_W'(sum_q);
      MODE_ATT:  work_d = RAD_W'(sum_q >> (2 * FRACTION_BITS));
      default:   work_d = {sum_q, 2'b00};
    endcase
  end

  always_comb begin
    r_ext = RND_W'(root_q);
    unique case (mode_q)
      MODE_CEIL: begin
        if (rem_q == '0) begin
          rnd = (r_ext + CEIL_ADD) >> FRACTION_BITS;
        end else begin
          rnd = (r_ext >> FRACTION_BITS) + RND_W'(1);
        end
      end
      MODE_ATT: begin
        rnd = (rem_q == '0) ? r_ext : r_ext + RND_W'(1);
      end
      default: begin
        rnd = ((r_ext >> FRACTION_BITS) + RND_W'(1)) >> 1;
      end
    endcase
    if (rnd > RND_W'(DIST_MAX)) begin
      dist_d = DIST_MAX;
    end else begin
      dist_d = rnd[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      x_mem[addr_a_q] <= cx_q;
      y_mem[addr_a_q] <= cy_q;
    end
    xa_q <= x_mem[addr_a_q];
    xb_q <= x_mem[addr_b_q];
    ya_q <= y_mem[addr_a_q];
    yb_q <= y_mem[addr_b_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_ROUND;
      strobe_q <= 1'b0;
    end else begin
      if (cfg_write_i) begin
        mode_q <= cfg_data_i;
      end
      strobe_q <= cmd_i.round;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= opcode_i;
      idx_a_q <= first_index_i;
      idx_b_q <= second_index_i;
      cx_q    <= coord_x_i;
      cy_q    <= coord_y_i;
    end
    if (cmd_i.quot) begin
      quot_a_q <= prod_a[PROD_W-1 -: INDEX_W];
      quot_b_q <= prod_b[PROD_W-1 -: INDEX_W];
    end
    if (cmd_i.reduce) begin
      addr_a_q <= red_a[ADDR_W-1:0];
      addr_b_q <= red_b[ADDR_W-1:0];
    end
    if (cmd_i.diff) begin
      mag_x_q <= dx[DIFF_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
      mag_y_q <= dy[DIFF_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
    end
    if (cmd_i.sq_x || cmd_i.sq_y) begin
      prod_q <= sq;
    end
    if (cmd_i.sq_y) begin
      acc_q <= prod_q;
    end
    if (cmd_i.sum) begin
      sum_q <= acc_q + prod_q;
    end
    if (cmd_i.load) begin
      work_q    <= work_d;
      sticky_q  <= |(sum_q & LOW_MASK);
      div_rem_q <= '0;
      root_q    <= '0;
      rem_q     <= '0;
    end
    if (cmd_i.div_step) begin
      work_q    <= {work_q[RAD_W-DIGIT_W-1:0], qbits};
      div_rem_q <= div_rem_d;
    end
    if (cmd_i.adjust) begin
      work_q <= work_q + RAD_W'(sticky_q || (div_rem_q != '0));
    end
    if (cmd_i.root_step) begin
      work_q <= {work_q[RAD_W-3:0], 2'b00};
      root_q <= root_d;
      rem_q  <= rem_d;
    end
    if (cmd_i.round) begin
      dist_q <= dist_d;
    end
  end

endmodule

>>> src/tour_point_distance_unit.sv
// ----------------------------------------------------------------------------
// Tour point distance unit
// Point table with integer distance queries under three rounding rules.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A store request
// writes coord_x_i and coord_y_i at first_index_i and gives no result. A
// query request reads both points and returns their distance. The 26-step
// square root yields one root bit per cycle; the pseudo-Euclidean mode
// adds a 13-step divide by ten and a correction step before it. The
// distance appears on distance_o, with result_strobe_o high for exactly one
// cycle, in the first cycle in which busy is low again. The receiver cannot
// stall the result. The mode register is written through cfg_valid_i and
// cfg_data_i while the unit is idle; the user must keep to this, as the
// block itself does not enforce it; cfg_ready_o is always high.
// Reset clears the controller and sets the mode to rounded Euclidean.
// The point tables are not cleared, so a point must be stored before use.
// Indices wrap modulo POINT_COUNT.
// ----------------------------------------------------------------------------
module tour_point_distance_unit #(
  parameter int unsigned POINT_COUNT   = 1024,
  parameter int unsigned FRACTION_BITS = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                opcode_i,
  input  logic [tpdu_pkg::INDEX_W-1:0]        first_index_i,
  input  logic [tpdu_pkg::INDEX_W-1:0]        second_index_i,
  input  logic signed [tpdu_pkg::COORD_W-1:0] coord_x_i,
  input  logic signed [tpdu_pkg::COORD_W-1:0] coord_y_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tpdu_pkg::MODE_W-1:0]         cfg_data_i,
  output logic                                result_strobe_o,
  output logic [tpdu_pkg::DIST_W-1:0]         distance_o
);
  import tpdu_pkg::*;

  tpdu_cmd_t    cmd;
  tpdu_status_t status;

  assign cfg_ready_o = 1'b1;

  tpdu_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .busy_o   (busy),
    .cmd_o    (cmd)
  );

  tpdu_datapath #(
    .POINT_COUNT   (POINT_COUNT),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_write_i     (cfg_valid_i && cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .opcode_i        (opcode_i),
    .first_index_i   (first_index_i),
    .second_index_i  (second_index_i),
    .coord_x_i       (coord_x_i),
    .coord_y_i       (coord_y_i),
    .result_strobe_o (result_strobe_o),
    .distance_o      (distance_o)
  );

`ifndef SYNTHESIS
  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy did not rise after an accepted request");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |=> !result_strobe_o)
    else $error("result strobe lasted more than one cycle");

  a_strobe_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> !busy)
    else $error("result strobe while the unit is busy");
`endif

endmodule
